// ===== design/assert_macros.svh =====
// Assertion macros shared by the kernel matcher RTL.
// Depends on nothing; define SYNTHESIS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== design/eigdkm_pkg.sv =====
// Types and constants of the eigen descriptor kernel matcher.
// No dependencies.
package eigdkm_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_MATCH = 1'b1;

  localparam logic [1:0] REG_KERNEL_COUNT = 2'd0;
  localparam logic [1:0] REG_EVAL_SIM     = 2'd1;
  localparam logic [1:0] REG_EVEC_SIM     = 2'd2;

  localparam logic [15:0] EVAL_SIM_RESET = 16'd26214;
  localparam logic [15:0] EVEC_SIM_RESET = 16'd29491;
  localparam logic [16:0] COS_ONE        = 17'd32768;

  // multiply-accumulate steps per cosine, divider quotient bits
  localparam int MAC_STEPS = 6;
  localparam int DIV_BITS  = 18;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_MAC,
    ST_PROD,
    ST_SQRT,
    ST_DIV,
    ST_SCORE,
    ST_NEXT,
    ST_DONE
  } state_t;

endpackage

// ===== design/eigdkm_item_if.sv =====
// Input item channel of the kernel matcher.
// No dependencies.
interface eigdkm_item_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [7:0]         kernel_index;
  logic [15:0]        eigenvalue_first;
  logic [15:0]        eigenvalue_second;
  logic signed [15:0] vector_a_x;
  logic signed [15:0] vector_a_y;
  logic signed [15:0] vector_b_x;
  logic signed [15:0] vector_b_y;
  logic [31:0]        stamp;
  logic [6:0]         centre_x;
  logic [6:0]         centre_y;
  logic               last_descriptor;

  modport source (output valid, op, kernel_index, eigenvalue_first, eigenvalue_second,
                  vector_a_x, vector_a_y, vector_b_x, vector_b_y, stamp, centre_x,
                  centre_y, last_descriptor, input ready);
  modport sink (input valid, op, kernel_index, eigenvalue_first, eigenvalue_second,
                vector_a_x, vector_a_y, vector_b_x, vector_b_y, stamp, centre_x,
                centre_y, last_descriptor, output ready);
endinterface

// ===== design/eigdkm_result_if.sv =====
// Result channel of the kernel matcher.
// No dependencies.
interface eigdkm_result_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [7:0]  best_kernel;
  logic [31:0] out_stamp;
  logic [6:0]  out_x;
  logic [6:0]  out_y;
  logic        out_last;

  modport source (output valid, found, best_kernel, out_stamp, out_x, out_y, out_last,
                  input ready);
  modport sink (input valid, found, best_kernel, out_stamp, out_x, out_y, out_last,
                output ready);
endinterface

// ===== design/eigdkm_cfg_if.sv =====
// Register write channel of the kernel matcher.
// No dependencies.
interface eigdkm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/eigen_descriptor_kernel_match.sv =====
// Eigen descriptor kernel matcher: kernel table, scan sequencer and cosine unit.
// Depends on eigdkm_pkg, the three eigdkm_*_if interfaces, assert_macros.svh.
//
//  channel  | dir | word
//  ---------+-----+-----------------------------------------------------------
//  items    | in  | op, kernel_index, eigenvalues, vectors, stamp, centre, last
//  results  | out | found, best_kernel, out_stamp, out_x, out_y, out_last
//  cfg      | in  | index (0 count, 1 eigenvalue sim, 2 eigenvector sim), data
//
// A load word writes the kernel memory directly. A match word walks kernels
// 0..n-1 through one shared cosine unit: a kernel whose eigenvalues pass is
// read and tested, then per eigenvector takes 6 MAC steps, one 32x32 product,
// 32 root steps, 18 divide steps and one score; a kernel failing the eigenvalue
// test is only read and tested. Synchronous reset clears control and the kernel
// count and presets the two similarity registers; the memory needs no clear. A
// finished result waits in the output register while the next word is taken;
// the scan stalls at its end only while that register is still full.
`include "assert_macros.svh"

module eigen_descriptor_kernel_match #(
  parameter int KERNELS = 256
) (
  input logic              clk,
  input logic              rst,
  eigdkm_item_if.sink      items,
  eigdkm_result_if.source  results,
  eigdkm_cfg_if.sink       cfg
);

  localparam int KIW = (KERNELS > 1) ? $clog2(KERNELS) : 1;  // table address
  localparam int CW  = $clog2(KERNELS + 1);                  // counts 0..KERNELS

  eigdkm_pkg::state_t state, state_next;

  // registers
  logic [8:0]  kernel_count;
  logic [15:0] eval_sim;
  logic [15:0] evec_sim;

  // kernel table: {b_y, b_x, a_y, a_x, eig1, eig0}
  logic [95:0] kmem [KERNELS];
  logic [95:0] rd_data;

  // descriptor held for the scan
  logic [15:0]        d_e0, d_e1;
  logic signed [15:0] d_ax, d_ay, d_bx, d_by;
  logic [31:0]        d_stamp;
  logic [6:0]         d_x, d_y;
  logic               d_last;

  // scan control
  logic [CW-1:0]  scan_idx, scan_limit;
  logic           vec_sel;        // 0: first eigenvector pair, 1: second
  logic [4:0]     step;
  logic           found;
  logic [KIW-1:0] best;
  logic [17:0]    best_score;
  logic [16:0]    cos_first;

  // cosine unit
  logic [31:0]        norm_u, norm_v;
  logic signed [32:0] dot;
  logic [31:0]        abs_dot;
  logic [63:0]        sq_rem, sq_root, sq_bit;
  logic [31:0]        div_rem;
  logic [17:0]        div_num;
  logic [17:0]        quot;

  // output register
  logic        res_valid;
  logic        res_found;
  logic [7:0]  res_best;
  logic [31:0] res_stamp;
  logic [6:0]  res_x, res_y;
  logic        res_last;

  logic in_take, take_load, take_match, res_free;
  assign in_take    = items.valid && items.ready;
  assign take_load  = in_take && (items.op == eigdkm_pkg::OP_LOAD);
  assign take_match = in_take && (items.op == eigdkm_pkg::OP_MATCH);
  assign res_free   = !res_valid || results.ready;

  // ---------------------------------------------------------------- eigen test
  function automatic logic eig_ok(input logic [15:0] d, input logic [15:0] k,
                                  input logic [15:0] sim);
    logic [15:0] mn, mx;
    logic [31:0] lhs, rhs;
    mn  = (d < k) ? d : k;
    mx  = (d < k) ? k : d;
    lhs = {1'b0, mn, 15'd0};
    rhs = sim * mx;
    return (mx != 16'd0) && (lhs >= rhs);
  endfunction

  logic eig_pass;
  assign eig_pass = eig_ok(d_e0, rd_data[15:0], eval_sim)
                 && eig_ok(d_e1, rd_data[31:16], eval_sim);

  // ---------------------------------------------------------------- MAC operands
  logic signed [15:0] ux, uy, vx, vy, mul_a, mul_b;
  logic signed [31:0] prod;
  assign ux = vec_sel ? d_bx : d_ax;
  assign uy = vec_sel ? d_by : d_ay;
  assign vx = vec_sel ? rd_data[79:64] : rd_data[47:32];
  assign vy = vec_sel ? rd_data[95:80] : rd_data[63:48];

  always_comb begin
    unique case (step[2:0])
      3'd0:    begin mul_a = ux; mul_b = ux; end
      3'd1:    begin mul_a = uy; mul_b = uy; end
      3'd2:    begin mul_a = vx; mul_b = vx; end
      3'd3:    begin mul_a = vy; mul_b = vy; end
      3'd4:    begin mul_a = ux; mul_b = vx; end
      default: begin mul_a = uy; mul_b = vy; end
    endcase
  end
  assign prod = mul_a * mul_b;

  // ---------------------------------------------------------------- root / divide
  logic [63:0] sq_trial;
  logic        sq_take;
  assign sq_trial = sq_root + sq_bit;
  assign sq_take  = sq_rem >= sq_trial;

  logic [32:0] div_shift;
  logic        div_take;
  assign div_shift = {div_rem, div_num[17]};
  assign div_take  = div_shift >= {1'b0, sq_root[31:0]};

  logic [16:0] cos_val;
  logic        cos_pass;
  logic [17:0] score;
  assign cos_val  = (quot > 18'(eigdkm_pkg::COS_ONE)) ? eigdkm_pkg::COS_ONE : quot[16:0];
  assign cos_pass = cos_val >= {1'b0, evec_sim};
  assign score    = {1'b0, cos_first} + {1'b0, cos_val};

  logic last_kernel;
  assign last_kernel = (scan_idx + CW'(1)) == scan_limit;

  logic [CW-1:0] limit_now;
  assign limit_now = (32'(kernel_count) > KERNELS) ? CW'(KERNELS) : CW'(kernel_count);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      eigdkm_pkg::ST_IDLE: begin
        if (take_match) begin
          state_next = (limit_now == '0) ? eigdkm_pkg::ST_DONE : eigdkm_pkg::ST_READ;
        end
      end
      eigdkm_pkg::ST_READ:  state_next = eigdkm_pkg::ST_EVAL;
      eigdkm_pkg::ST_EVAL: begin
        state_next = eig_pass ? eigdkm_pkg::ST_MAC : eigdkm_pkg::ST_NEXT;
      end
      eigdkm_pkg::ST_MAC: begin
        if (step == 5'(eigdkm_pkg::MAC_STEPS - 1)) state_next = eigdkm_pkg::ST_PROD;
      end
      eigdkm_pkg::ST_PROD: begin
        state_next = (norm_u == '0 || norm_v == '0) ? eigdkm_pkg::ST_NEXT
                                                   : eigdkm_pkg::ST_SQRT;
      end
      eigdkm_pkg::ST_SQRT: begin
        if (sq_bit[0]) state_next = eigdkm_pkg::ST_DIV;
      end
      eigdkm_pkg::ST_DIV: begin
        if (step == '0) state_next = eigdkm_pkg::ST_SCORE;
      end
      eigdkm_pkg::ST_SCORE: begin
        if (cos_pass && !vec_sel) state_next = eigdkm_pkg::ST_MAC;
        else state_next = eigdkm_pkg::ST_NEXT;
      end
      eigdkm_pkg::ST_NEXT: begin
        state_next = last_kernel ? eigdkm_pkg::ST_DONE : eigdkm_pkg::ST_READ;
      end
      eigdkm_pkg::ST_DONE: begin
        if (res_free) state_next = eigdkm_pkg::ST_IDLE;
      end
      default: state_next = eigdkm_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- handshake outputs
  always_comb begin
    items.ready = (state == eigdkm_pkg::ST_IDLE);
    cfg.ready   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= eigdkm_pkg::ST_IDLE;
    else state <= state_next;
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_count <= '0;
      eval_sim     <= eigdkm_pkg::EVAL_SIM_RESET;
      evec_sim     <= eigdkm_pkg::EVEC_SIM_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        eigdkm_pkg::REG_KERNEL_COUNT: kernel_count <= cfg.data[8:0];
        eigdkm_pkg::REG_EVAL_SIM:     eval_sim     <= cfg.data;
        eigdkm_pkg::REG_EVEC_SIM:     evec_sim     <= cfg.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- kernel memory
  always_ff @(posedge clk) begin
    if (take_load && (32'(items.kernel_index) < KERNELS)) begin
      kmem[KIW'(items.kernel_index)] <= {items.vector_b_y, items.vector_b_x,
                                         items.vector_a_y, items.vector_a_x,
                                         items.eigenvalue_second, items.eigenvalue_first};
    end
    if (state == eigdkm_pkg::ST_READ) rd_data <= kmem[scan_idx[KIW-1:0]];
  end

  // ---------------------------------------------------------------- descriptor capture
  always_ff @(posedge clk) begin
    if (take_match) begin
      d_e0    <= items.eigenvalue_first;
      d_e1    <= items.eigenvalue_second;
      d_ax    <= items.vector_a_x;
      d_ay    <= items.vector_a_y;
      d_bx    <= items.vector_b_x;
      d_by    <= items.vector_b_y;
      d_stamp <= items.stamp;
      d_x     <= items.centre_x;
      d_y     <= items.centre_y;
      d_last  <= items.last_descriptor;
    end
  end

  // ---------------------------------------------------------------- scan datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      scan_limit <= '0;
      vec_sel    <= 1'b0;
      step       <= '0;
      found      <= 1'b0;
      best       <= '0;
      best_score <= '0;
    end else begin
      unique case (state)
        eigdkm_pkg::ST_IDLE: begin
          scan_idx   <= '0;
          scan_limit <= limit_now;
          found      <= 1'b0;
          best       <= '0;
          best_score <= '0;
        end
        eigdkm_pkg::ST_EVAL: begin
          vec_sel <= 1'b0;
          step    <= '0;
        end
        eigdkm_pkg::ST_MAC: step <= step + 5'd1;
        eigdkm_pkg::ST_SQRT: step <= 5'(eigdkm_pkg::DIV_BITS - 1);
        eigdkm_pkg::ST_DIV: step <= step - 5'd1;
        eigdkm_pkg::ST_SCORE: begin
          if (cos_pass && !vec_sel) begin
            vec_sel <= 1'b1;
            step    <= '0;
          end else if (cos_pass) begin
            if (!found || score > best_score) begin
              best       <= scan_idx[KIW-1:0];
              best_score <= score;
            end
            found <= 1'b1;
          end
        end
        eigdkm_pkg::ST_NEXT: scan_idx <= scan_idx + CW'(1);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- cosine unit
  always_ff @(posedge clk) begin
    unique case (state)
      eigdkm_pkg::ST_MAC: begin
        unique case (step[2:0])
          3'd0:    norm_u <= 32'(prod);
          3'd1:    norm_u <= norm_u + 32'(prod);
          3'd2:    norm_v <= 32'(prod);
          3'd3:    norm_v <= norm_v + 32'(prod);
          3'd4:    dot    <= 33'(prod);
          default: dot    <= dot + 33'(prod);
        endcase
      end
      eigdkm_pkg::ST_PROD: begin
        sq_rem  <= norm_u * norm_v;
        sq_root <= '0;
        sq_bit  <= 64'd1 << 62;
        abs_dot <= dot[32] ? 32'(-dot) : dot[31:0];
      end
      eigdkm_pkg::ST_SQRT: begin
        if (sq_take) begin
          sq_rem  <= sq_rem - sq_trial;
          sq_root <= (sq_root >> 1) + sq_bit;
        end else begin
          sq_root <= sq_root >> 1;
        end
        sq_bit <= sq_bit >> 2;
        // numerator abs_dot << 15: its top bits start the remainder
        div_rem <= 32'(abs_dot[31:3]);
        div_num <= {abs_dot[2:0], 15'd0};
        quot    <= '0;
      end
      eigdkm_pkg::ST_DIV: begin
        div_rem <= div_take ? 32'(div_shift - {1'b0, sq_root[31:0]}) : div_shift[31:0];
        div_num <= div_num << 1;
        quot    <= {quot[16:0], div_take};
      end
      eigdkm_pkg::ST_SCORE: begin
        if (!vec_sel) cos_first <= cos_val;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == eigdkm_pkg::ST_DONE && res_free) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == eigdkm_pkg::ST_DONE && res_free) begin
      res_found <= found;
      res_best  <= found ? 8'(best) : 8'd0;
      res_stamp <= d_stamp;
      res_x     <= d_x;
      res_y     <= d_y;
      res_last  <= d_last;
    end
  end

  assign results.valid       = res_valid;
  assign results.found       = res_found;
  assign results.best_kernel = res_best;
  assign results.out_stamp   = res_stamp;
  assign results.out_x       = res_x;
  assign results.out_y       = res_y;
  assign results.out_last    = res_last;

  // ---------------------------------------------------------------- checks
  `ASSERT_PROP(a_scan_in_range, clk, rst, (state == eigdkm_pkg::ST_READ) |-> (scan_idx < scan_limit), "scan index past kernel count")
  `ASSERT_PROP(a_miss_zero_best, clk, rst, (results.valid && !results.found) |-> (results.best_kernel == 8'd0), "miss with nonzero kernel")
  `ASSERT_PROP(a_root_nonzero, clk, rst, (state == eigdkm_pkg::ST_DIV) |-> (sq_root != '0), "divide by zero root")
  `ASSERT_PROP(a_match_blocks, clk, rst, take_match |=> !items.ready, "input taken during scan")

endmodule

// ===== tb/sv/eigen_descriptor_kernel_match_tb.sv =====
// Self-checking bench for eigen_descriptor_kernel_match: loads kernels,
// matches descriptors, compares every result against an in-bench predictor.
// Depends on eigdkm_pkg and the eigdkm_item_if, eigdkm_result_if, eigdkm_cfg_if interfaces.
module eigen_descriptor_kernel_match_tb;

  localparam int NKERN     = 256;
  localparam int LIMIT     = 4000000;   // cycles before the run is declared hung
  localparam int HOLD_LEN  = 3000;      // long receiver back-pressure stretch
  localparam int HOLD_AT   = 420;       // accepted-word count that triggers it

  typedef struct packed {
    logic               op;
    logic [7:0]         kidx;
    logic [15:0]        ev0;
    logic [15:0]        ev1;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic [31:0]        stamp;
    logic [6:0]         cx;
    logic [6:0]         cy;
    logic               last;
  } word_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  best;
    logic [31:0] stamp;
    logic [6:0]  x;
    logic [6:0]  y;
    logic        last;
  } match_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  eigdkm_item_if   item_ch ();
  eigdkm_result_if res_ch ();
  eigdkm_cfg_if    cfg_ch ();

  eigen_descriptor_kernel_match #(.KERNELS(NKERN)) uut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch.sink),
    .results (res_ch.source),
    .cfg     (cfg_ch.sink)
  );

  // Predictor state: kernel table mirror and register copies.
  logic [15:0]        tab_ev0 [NKERN];
  logic [15:0]        tab_ev1 [NKERN];
  logic signed [15:0] tab_v   [NKERN][4];
  bit                 tab_wr  [NKERN];
  logic [8:0]         kcount  = 9'd0;
  logic [15:0]        evsim   = eigdkm_pkg::EVAL_SIM_RESET;
  logic [15:0]        vecsim  = eigdkm_pkg::EVEC_SIM_RESET;

  word_t  word_q[$];     // words waiting for the driver
  match_t match_q[$];    // predicted results not yet seen
  int     errors    = 0;
  int     accepted  = 0;
  int     n_loads   = 0;
  int     n_matches = 0;
  int     n_found   = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;
  longint cycles    = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q1.15 absolute cosine, -1 when either vector has zero norm.
  function automatic int abs_cosine(longint ux, longint uy, longint vx, longint vy);
    longint unsigned nu, nv, ad, r, c;
    longint dot;
    nu = ux * ux + uy * uy;
    nv = vx * vx + vy * vy;
    dot = ux * vx + uy * vy;
    ad = (dot < 0) ? -dot : dot;
    if (nu == 0 || nv == 0) return -1;
    r = root64(nu * nv);
    if (r == 0) return -1;
    c = (ad * 32768) / r;
    if (c > 32768) c = 32768;
    return int'(c);
  endfunction

  function automatic bit eig_close(logic [15:0] d, logic [15:0] k);
    longint unsigned mn, mx;
    mn = (d < k) ? d : k;
    mx = (d < k) ? k : d;
    if (mx == 0) return 1'b0;
    return mn * 32768 >= longint'(evsim) * mx;
  endfunction

  function automatic match_t best_match(word_t w);
    match_t m;
    int n, c0, c1;
    int unsigned score, top;
    bit hit;
    hit = 1'b0;
    top = 0;
    m = '0;
    n = (kcount > NKERN) ? NKERN : kcount;
    for (int i = 0; i < n; i++) begin
      if (!eig_close(w.ev0, tab_ev0[i]) || !eig_close(w.ev1, tab_ev1[i])) continue;
      c0 = abs_cosine(w.ax, w.ay, tab_v[i][0], tab_v[i][1]);
      c1 = abs_cosine(w.bx, w.by, tab_v[i][2], tab_v[i][3]);
      if (c0 < 0 || c1 < 0) continue;
      if (c0 < int'(vecsim) || c1 < int'(vecsim)) continue;
      score = c0 + c1;
      // strictly larger score replaces; first kernel wins ties
      if (!hit || score > top) begin
        top = score;
        m.best = i[7:0];
      end
      hit = 1'b1;
    end
    m.found = hit;
    m.stamp = w.stamp;
    m.x     = w.cx;
    m.y     = w.cy;
    m.last  = w.last;
    return m;
  endfunction

  function automatic void take_word(word_t w);
    if (w.op == eigdkm_pkg::OP_LOAD) begin
      tab_ev0[w.kidx] = w.ev0;
      tab_ev1[w.kidx] = w.ev1;
      tab_v[w.kidx][0] = w.ax;
      tab_v[w.kidx][1] = w.ay;
      tab_v[w.kidx][2] = w.bx;
      tab_v[w.kidx][3] = w.by;
      tab_wr[w.kidx] = 1'b1;
      n_loads++;
    end else begin
      match_q.push_back(best_match(w));
      n_matches++;
    end
  endfunction

  // Random idling, off during one quiet stretch of accepted words.
  function automatic bit idle_now();
    if (accepted >= 300 && accepted < 360) return 1'b0;
    return $urandom_range(99) < 33;
  endfunction

  // ------------------------------------------------------------------ driver
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      item_ch.op <= eigdkm_pkg::OP_LOAD;
      item_ch.kernel_index <= '0;
      item_ch.eigenvalue_first <= '0;
      item_ch.eigenvalue_second <= '0;
      item_ch.vector_a_x <= '0;
      item_ch.vector_a_y <= '0;
      item_ch.vector_b_x <= '0;
      item_ch.vector_b_y <= '0;
      item_ch.stamp <= '0;
      item_ch.centre_x <= '0;
      item_ch.centre_y <= '0;
      item_ch.last_descriptor <= 1'b0;
    end else begin
      word_t w;
      if (item_ch.valid && item_ch.ready) begin
        take_word(word_t'{item_ch.op, item_ch.kernel_index, item_ch.eigenvalue_first,
                          item_ch.eigenvalue_second, item_ch.vector_a_x,
                          item_ch.vector_a_y, item_ch.vector_b_x, item_ch.vector_b_y,
                          item_ch.stamp, item_ch.centre_x, item_ch.centre_y,
                          item_ch.last_descriptor});
        accepted++;
      end
      // hold the word until it is taken
      if (!item_ch.valid || item_ch.ready) begin
        if (word_q.size() != 0 && !idle_now()) begin
          w = word_q.pop_front();
          item_ch.valid <= 1'b1;
          item_ch.op <= w.op;
          item_ch.kernel_index <= w.kidx;
          item_ch.eigenvalue_first <= w.ev0;
          item_ch.eigenvalue_second <= w.ev1;
          item_ch.vector_a_x <= w.ax;
          item_ch.vector_a_y <= w.ay;
          item_ch.vector_b_x <= w.bx;
          item_ch.vector_b_y <= w.by;
          item_ch.stamp <= w.stamp;
          item_ch.centre_x <= w.cx;
          item_ch.centre_y <= w.cy;
          item_ch.last_descriptor <= w.last;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------- back-pressure hold
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && accepted >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ----------------------------------------------------------------- monitor
  task automatic report(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
             n_found);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      match_t e;
      cycles++;
      if (cycles > LIMIT) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Verification failed");
        $finish;
      end else begin
        if (res_ch.valid && res_ch.ready) begin
          if (match_q.size() == 0) begin
            report("unexpected result", res_ch.out_stamp, -1);
          end else begin
            e = match_q.pop_front();
            if (res_ch.found !== e.found) report("found", res_ch.found, e.found);
            if (res_ch.best_kernel !== e.best) report("best_kernel", res_ch.best_kernel, e.best);
            if (res_ch.out_stamp !== e.stamp) report("out_stamp", res_ch.out_stamp, e.stamp);
            if (res_ch.out_x !== e.x) report("out_x", res_ch.out_x, e.x);
            if (res_ch.out_y !== e.y) report("out_y", res_ch.out_y, e.y);
            if (res_ch.out_last !== e.last) report("out_last", res_ch.out_last, e.last);
            if (e.found) n_found++;
          end
        end
        res_ch.ready <= (hold_left > 0) ? 1'b0 : !idle_now();
      end
    end
  end

  // --------------------------------------------------------------- stimulus
  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    case (idx)
      eigdkm_pkg::REG_KERNEL_COUNT: kcount = data[8:0];
      eigdkm_pkg::REG_EVAL_SIM:     evsim = data;
      eigdkm_pkg::REG_EVEC_SIM:     vecsim = data;
      default: ;
    endcase
  endtask

  task automatic set_regs(int cnt, int es, int vs);
    write_reg(eigdkm_pkg::REG_KERNEL_COUNT, cnt[15:0]);
    write_reg(eigdkm_pkg::REG_EVAL_SIM, es[15:0]);
    write_reg(eigdkm_pkg::REG_EVEC_SIM, vs[15:0]);
  endtask

  // all words taken, all results seen, then a short margin for a trailing load
  task automatic drain();
    do @(posedge clk); while (word_q.size() != 0 || item_ch.valid || match_q.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rnd_comp();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic word_t load_word(int k);
    word_t w;
    w = '0;
    w.op = eigdkm_pkg::OP_LOAD;
    w.kidx = k[7:0];
    w.ev0 = ($urandom_range(15) == 0) ? 16'hffff : 16'($urandom());
    w.ev1 = ($urandom_range(15) == 0) ? 16'h0000 : 16'($urandom());
    w.ax = rnd_comp();
    w.ay = rnd_comp();
    w.bx = rnd_comp();
    w.by = rnd_comp();
    w.stamp = $urandom();
    w.cx = 7'($urandom());
    w.cy = 7'($urandom());
    w.last = 1'($urandom());
    return w;
  endfunction

  function automatic logic signed [15:0] jitter(logic signed [15:0] v, int amt);
    int t;
    t = int'(v) + $urandom_range(2 * amt) - amt;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return t[15:0];
  endfunction

  function automatic logic [15:0] jitter_ev(logic [15:0] v, int amt);
    int t;
    t = int'(v) + $urandom_range(2 * amt) - amt;
    if (t > 65535) t = 65535;
    if (t < 0) t = 0;
    return t[15:0];
  endfunction

  // A descriptor near a loaded kernel, so the scan gets past the tests.
  function automatic word_t near_word(int k, int amt);
    word_t w;
    w = load_word(0);
    w.op = eigdkm_pkg::OP_MATCH;
    w.kidx = 8'($urandom());
    w.ev0 = jitter_ev(tab_ev0[k], amt * 2);
    w.ev1 = jitter_ev(tab_ev1[k], amt * 2);
    w.ax = jitter(tab_v[k][0], amt);
    w.ay = jitter(tab_v[k][1], amt);
    w.bx = jitter(tab_v[k][2], amt);
    w.by = jitter(tab_v[k][3], amt);
    if ($urandom_range(1)) begin   // opposite sign gives the same absolute cosine
      w.ax = -w.ax;
      w.ay = -w.ay;
    end
    return w;
  endfunction

  function automatic word_t kern_word(int k, int e0, int e1, int ax, int ay, int bx, int by);
    word_t w;
    w = load_word(k);
    w.ev0 = e0[15:0];
    w.ev1 = e1[15:0];
    w.ax = ax[15:0];
    w.ay = ay[15:0];
    w.bx = bx[15:0];
    w.by = by[15:0];
    return w;
  endfunction

  task automatic rand_phase(int cnt, int es, int vs, int nwords);
    word_t w;
    int k;
    set_regs(cnt, es, vs);
    for (int i = 0; i < nwords; i++) begin
      k = (cnt == 0) ? 0 : $urandom_range(((cnt > NKERN) ? NKERN : cnt) - 1);
      case ($urandom_range(9))
        0, 1: word_q.push_back(load_word($urandom_range(NKERN - 1)));
        2: begin
          w = load_word(0);
          w.op = eigdkm_pkg::OP_MATCH;
          word_q.push_back(w);
        end
        3: word_q.push_back(near_word(k, 0));
        default: word_q.push_back(near_word(k, $urandom_range(4000)));
      endcase
    end
    drain();
  endtask

  initial begin
    word_t w;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = eigdkm_pkg::REG_KERNEL_COUNT;
    cfg_ch.data = '0;
    for (int i = 0; i < NKERN; i++) tab_wr[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: match with no kernels searched, then special kernels.
    w = load_word(0);
    w.op = eigdkm_pkg::OP_MATCH;
    w.stamp = 32'hffffffff;
    w.cx = 7'h7f;
    w.cy = 7'h00;
    w.last = 1'b1;
    word_q.push_back(w);
    word_q.push_back(kern_word(0, 0, 0, 20000, 3000, -3000, 20000));           // zero pair
    word_q.push_back(kern_word(1, 30000, 9000, 0, 0, 1000, 1000));             // zero vector
    word_q.push_back(kern_word(2, 65535, 65535, -32768, -32768, 32767, -32768));
    word_q.push_back(kern_word(3, 40000, 12000, 20000, 5000, -5000, 20000));   // tie pair
    word_q.push_back(kern_word(4, 40000, 12000, 20000, 5000, -5000, 20000));
    word_q.push_back(kern_word(5, 40000, 12000, 19000, 7000, -7000, 19000));
    drain();
    write_reg(eigdkm_pkg::REG_KERNEL_COUNT, 16'd6);
    word_q.push_back(near_word(3, 0));   // tie: first of 3,4 wins
    word_q.push_back(near_word(5, 0));
    word_q.push_back(near_word(2, 0));   // all extremes
    w = near_word(0, 0);                 // zero eigenvalue descriptor
    w.ev0 = 16'h0000;
    w.ev1 = 16'h0000;
    word_q.push_back(w);
    w = near_word(3, 0);                 // zero vector descriptor
    w.bx = 16'sh0000;
    w.by = 16'sh0000;
    word_q.push_back(w);
    drain();
    write_reg(eigdkm_pkg::REG_EVEC_SIM, 16'd0);      // zero score kernels still qualify
    w = near_word(3, 0);
    w.ax = 16'sh0000;
    w.ay = 16'sh7fff;
    w.bx = 16'sh7fff;
    w.by = 16'sh0000;
    word_q.push_back(w);
    drain();

    // Fill every table slot so any count is legal from here on.
    for (int i = 6; i < NKERN; i++) word_q.push_back(load_word(i));
    drain();

    rand_phase(6, 26214, 29491, 45);
    rand_phase(8, 0, 0, 45);
    rand_phase(12, 32768, 32768, 45);
    rand_phase(16, 65535, 65535, 30);
    rand_phase(5, 16000, 20000, 60);
    rand_phase(10, 30000, 31000, 45);
    rand_phase(1, 1, 29491, 25);
    rand_phase(511, 65535, 29491, 8);    // count beyond table, all eigen tests fail
    rand_phase(256, 32768, 0, 8);        // full table, only equal eigenvalues pass

    repeat (200) @(posedge clk);
    $display("Covered %0d loads and %0d matches (%0d found) over %0d cycles,",
             n_loads, n_matches, n_found, cycles);
    $display("nine register settings including range extremes and a full-table scan.");
    if (errors == 0 && match_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/eigdkm_pkg.sv
design/eigdkm_item_if.sv
design/eigdkm_result_if.sv
design/eigdkm_cfg_if.sv
design/eigen_descriptor_kernel_match.sv
tb/sv/eigen_descriptor_kernel_match_tb.sv
